@@ src/assert_macros.svh @@
// Assertion helper macros for the test signal generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPLY(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m");
`define CHK_NEXT(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`else
`define CHK_IMPLY(label, clk, rst_n, a, b)
`define CHK_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ src/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants of the test signal generator.
// ----------------------------------------------------------------------------
package tsg_pkg;
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [2:0] MODE_PULSE  = 3'd0;
	localparam logic [2:0] MODE_STEP   = 3'd1;
	localparam logic [2:0] MODE_RAMP   = 3'd2;
	localparam logic [2:0] MODE_SINE   = 3'd3;
	localparam logic [2:0] MODE_SQUARE = 3'd4;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_LOW  = 3'd1;
	localparam logic [2:0] REG_HIGH = 3'd2;
	localparam logic [2:0] REG_INTV = 3'd3;
	localparam logic [2:0] REG_SLOPE = 3'd4;
	localparam logic [2:0] REG_AMP  = 3'd5;
	localparam logic [2:0] REG_PSTEP = 3'd6;
	localparam logic [2:0] REG_OFS  = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] level_low;
		logic [31:0] level_high;
		logic [31:0] interval_ticks;
		logic [31:0] ramp_slope;
		logic [31:0] sine_amplitude;
		logic [31:0] sine_phase_step;
		logic [31:0] sine_offset;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture input item
		logic calc1;  // first compute step
		logic calc2;  // second compute step
		logic fin;    // final result step
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

@@ src/test_signal_generator_top.sv @@
// ----------------------------------------------------------------------------
// test_signal_generator_top
// Pulse, step, ramp, sine and square test signal generator, Q16.16 output.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// s_axis   | in  | tdata[31:0] time_now; tuser[2:0] fire_pulse, step_high, ramp_down
// m_axis   | out | tdata[31:0] signal_value
// cfg      | in  | cfg_index[2:0], cfg_data[31:0]
// The result is valid once the item has passed state update and phase product,
// ramp product and table read, sine product, and select, in that order.
// The result is held until taken; the next item is accepted on the following
// edge, so no new item is taken while one is still in progress.
// Reset is asynchronous; the configuration port is always ready.
// ----------------------------------------------------------------------------
module test_signal_generator_top #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int TIME_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // time_now
	input  logic [2:0]  s_axis_tuser,  // fire_pulse, step_high, ramp_down
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // signal_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [tsg_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import tsg_pkg::*;
	cmd_t cmd;
	logic out_v, fin_pend_q;

	assign cfg_ready = 1'b1;

	tsg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(out_v), .out_ready(m_axis_tready && !fin_pend_q),
		.cmd(cmd)
	);

	// hold off valid in the cycle after finish so the select register settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_pend_q <= 1'b0;
		else fin_pend_q <= cmd.fin;
	end
	assign m_axis_tvalid = out_v && !fin_pend_q;

	tsg_datapath #(.SINE_TABLE_BITS(SINE_TABLE_BITS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .time_now(s_axis_tdata),
		.fire_pulse(s_axis_tuser[0]), .step_high(s_axis_tuser[1]),
		.ramp_down(s_axis_tuser[2]), .signal_value(m_axis_tdata)
	);
endmodule

@@ src/tsg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// tsg_sine_rom
// Quarter-wave sine table in Q30, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module tsg_sine_rom #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                        clk,
	input  logic [SINE_TABLE_BITS-2:0]  addr,
	output logic [30:0]                 data
);
	localparam int QLEN = 1 << (SINE_TABLE_BITS - 2);

	function automatic logic [30:0] qsine(input longint unsigned q);
		longint unsigned x, x2, term;
		longint sum;
		x = (q * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		// odd Taylor terms up to x^11, alternating sign
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - longint'(term);
		if (sum < 0) sum = 0;
		if (sum > 64'sd1073741824) sum = 64'sd1073741824;
		return sum[30:0];
	endfunction

	logic [30:0] rom [QLEN+1];

	always_comb begin
		for (int i = 0; i <= QLEN; i++) rom[i] = qsine(longint'(i));
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end
endmodule

@@ src/tsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsg_ctrl
// Sequencer: load, two compute steps, finish, then hold the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tsg_pkg::cmd_t  cmd
);
	import tsg_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_C1   = 3'd1;
	localparam logic [2:0] ST_C2   = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.calc1 = (state_q == ST_C1);
	assign cmd.calc2 = (state_q == ST_C2);
	assign cmd.fin   = (state_q == ST_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_C1;
				ST_C1:   state_q <= ST_C2;
				ST_C2:   state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CHK_NEXT(a_load_c1, clk, arst_n, cmd.load, cmd.calc1)
	`CHK_NEXT(a_c1_c2, clk, arst_n, cmd.calc1, cmd.calc2)
	`CHK_NEXT(a_fin_out, clk, arst_n, cmd.fin, out_valid)
	`CHK_IMPLY(a_excl, clk, arst_n, out_valid, !in_ready)
endmodule

@@ src/tsg_datapath.sv @@
// ----------------------------------------------------------------------------
// tsg_datapath
// Registers, generator state and the shared arithmetic for one sample.
// ----------------------------------------------------------------------------
module tsg_datapath #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int TIME_WIDTH      = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [31:0]    cfg_data,
	input  tsg_pkg::cmd_t  cmd,
	input  logic [31:0]    time_now,
	input  logic           fire_pulse,
	input  logic           step_high,
	input  logic           ramp_down,
	output logic [31:0]    signal_value
);
	import tsg_pkg::*;
	localparam int B = SINE_TABLE_BITS;
	localparam int TW = TIME_WIDTH;

	cfg_t cfg_q;
	logic [TW-1:0] t_q, pulse_start_q, ramp_start_q, sq_time_q;
	logic ramp_dir_q, sq_level_q, fire_q, step_q, down_q;
	logic [31:0] phase_q, elapsed_q;
	logic [63:0] prod_q;
	logic neg_q;
	logic [31:0] res_q;
	logic [B-2:0] rom_addr;
	logic [30:0] rom_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: 3'd0, level_low: 32'd0, level_high: 32'd65536,
				interval_ticks: 32'd1000, default: 32'd0};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:  cfg_q.mode <= cfg_data[2:0];
				REG_LOW:   cfg_q.level_low <= cfg_data;
				REG_HIGH:  cfg_q.level_high <= cfg_data;
				REG_INTV:  cfg_q.interval_ticks <= cfg_data;
				REG_SLOPE: cfg_q.ramp_slope <= cfg_data;
				REG_AMP:   cfg_q.sine_amplitude <= cfg_data;
				REG_PSTEP: cfg_q.sine_phase_step <= cfg_data;
				REG_OFS:   cfg_q.sine_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// time difference against a start mark, modulo 2^TW
	logic [TW-1:0] t_in, d_pulse, d_ramp, d_sq;
	logic [63:0] intv_ext, t_x, d_ramp_x;
	assign t_in     = TW'({{(TW > 32 ? TW - 32 : 1){1'b0}}, time_now});
	assign d_pulse  = t_q - pulse_start_q;
	assign d_ramp   = t_q - ramp_start_q;
	assign d_sq     = t_q - sq_time_q;
	assign intv_ext = 64'(cfg_q.interval_ticks);
	assign t_x      = 64'(t_q);
	assign d_ramp_x = 64'(d_ramp);

	// sine index
	logic [B-1:0] idx;
	logic [B-3:0] r;
	logic [B-2:0] qarg;
	assign idx  = phase_q[31 -: B];
	assign r    = idx[B-3:0];
	assign qarg = idx[B-2] ? ((B-1)'(1) << (B - 2)) - (B-1)'(r) : (B-1)'(r);
	assign rom_addr = qarg;

	tsg_sine_rom #(.SINE_TABLE_BITS(B)) u_rom (
		.clk(clk), .addr(rom_addr), .data(rom_data)
	);

	logic signed [32:0] amp_s;
	logic [31:0] amp_mag;
	assign amp_s   = 33'(signed'(cfg_q.sine_amplitude));
	assign amp_mag = amp_s[32] ? 32'(-amp_s) : cfg_q.sine_amplitude;

	logic signed [65:0] ramp_v, sine_v, sine_p;
	logic signed [65:0] lo_x, hi_x;
	assign lo_x = 66'(signed'(cfg_q.level_low));
	assign hi_x = 66'(signed'(cfg_q.level_high));
	assign sine_p = 66'((prod_q + 64'd536870912) >> 30);

	always_comb begin
		if (!down_q) begin
			ramp_v = lo_x + 66'(signed'(prod_q));
			if (ramp_v > hi_x) ramp_v = hi_x;
		end else begin
			ramp_v = hi_x - 66'(signed'(prod_q));
			if (ramp_v < lo_x) ramp_v = lo_x;
		end
		sine_v = (neg_q ? -sine_p : sine_p) + 66'(signed'(cfg_q.sine_offset));
	end

	// generator state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_start_q <= '0;
			ramp_start_q  <= '0;
			sq_time_q     <= '0;
			ramp_dir_q    <= 1'b0;
			sq_level_q    <= 1'b0;
		end else begin
			if (cmd.calc1) begin
				unique case (cfg_q.mode)
					MODE_PULSE: if (fire_q) pulse_start_q <= t_q;
					MODE_RAMP: if (down_q != ramp_dir_q) begin
						ramp_dir_q   <= down_q;
						ramp_start_q <= t_q;
					end
					MODE_SQUARE: if (64'(d_sq) > intv_ext) begin
						sq_time_q  <= t_q;
						sq_level_q <= !sq_level_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q    <= t_in;
			fire_q <= fire_pulse;
			step_q <= step_high;
			down_q <= ramp_down;
		end
		if (cmd.calc1) begin
			// phase product here; ramp and sine products follow in later steps
			phase_q <= 32'(64'(cfg_q.sine_phase_step) * t_x);
			if (down_q != ramp_dir_q)
				elapsed_q <= 32'd0;
			else if (|d_ramp_x[63:32])
				elapsed_q <= 32'hffffffff;
			else
				elapsed_q <= d_ramp_x[31:0];
		end
		if (cmd.calc2) begin
			if (cfg_q.mode == MODE_RAMP)
				prod_q <= 64'($signed(cfg_q.ramp_slope)) * 64'($signed({1'b0, elapsed_q}));
			neg_q <= idx[B-1] ^ amp_s[32];
		end
		if (cmd.fin) begin
			if (cfg_q.mode == MODE_SINE)
				prod_q <= 64'(amp_mag) * 64'(rom_data);
		end
	end

	// final selection: made in the cycle after fin, once the sine product is registered
	logic fin_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_d <= 1'b0;
		else fin_d <= cmd.fin;
	end

	always_ff @(posedge clk) begin
		if (fin_d) begin
			unique case (cfg_q.mode)
				MODE_PULSE: res_q <= (64'(d_pulse) < intv_ext) ?
					cfg_q.level_high : cfg_q.level_low;
				MODE_STEP:   res_q <= step_q ? cfg_q.level_high : cfg_q.level_low;
				MODE_RAMP:   res_q <= sat32(ramp_v);
				MODE_SINE:   res_q <= sat32(sine_v);
				MODE_SQUARE: res_q <= sq_level_q ? cfg_q.level_high : cfg_q.level_low;
				default:     res_q <= 32'd0;
			endcase
		end
	end

	assign signal_value = res_q;
endmodule
